// ----- hdl/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// types and constants shared by the utf-16 to utf-8 transcoder modules
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned CuW     = 16;
  localparam int unsigned CpW     = 21;
  localparam int unsigned CapW    = 13;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatW   = 2;
  localparam int unsigned PendW   = 10;

  localparam logic [CapW-1:0] CapReset = 13'd2048;

  localparam logic [CuW-1:0] HiSurBase  = 16'hD800;
  localparam logic [CuW-1:0] LoSurBase  = 16'hDC00;
  localparam logic [CuW-1:0] SurEnd     = 16'hE000;
  localparam logic [CpW-1:0] SuppBase   = 21'h10000;
  localparam logic [CpW-1:0] Lim1Byte   = 21'h00080;
  localparam logic [CpW-1:0] Lim2Byte   = 21'h00800;

  localparam logic [ByteW-1:0] ContMark = 8'h80;
  localparam logic [ByteW-1:0] Lead2    = 8'hC0;
  localparam logic [ByteW-1:0] Lead3    = 8'hE0;
  localparam logic [ByteW-1:0] Lead4    = 8'hF0;

  localparam logic [StatW-1:0] StatRun    = 2'd0;
  localparam logic [StatW-1:0] StatOk     = 2'd1;
  localparam logic [StatW-1:0] StatBadSur = 2'd2;
  localparam logic [StatW-1:0] StatFull   = 2'd3;

  typedef enum logic [1:0] {
    KIND_CP,
    KIND_HOLD,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    logic [CpW-1:0] value;
    logic [1:0]     nb_m1;
    logic           last;
  } cmd_t;

endpackage

// ----- hdl/u16u8_front.sv -----
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, pairs surrogates and classifies each unit into a command
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u16u8_pkg::CuW-1:0]     in_code_unit,
  input  logic                          in_last_unit,
  output logic                          push,
  output u16u8_pkg::cmd_t               push_cmd,
  input  logic                          push_ready
);

  logic [u16u8_pkg::PendW-1:0] pend_r, pend_nxt;
  logic                        have_pend_r, have_pend_nxt;
  logic                        is_hi, is_lo;
  logic [u16u8_pkg::CpW-1:0]   pair_val;

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  assign is_hi = (in_code_unit >= u16u8_pkg::HiSurBase) && (in_code_unit < u16u8_pkg::LoSurBase);
  assign is_lo = (in_code_unit >= u16u8_pkg::LoSurBase) && (in_code_unit < u16u8_pkg::SurEnd);
  assign pair_val = {1'b0, pend_r, in_code_unit[9:0]} + u16u8_pkg::SuppBase;

  always_comb begin
    push_cmd.kind  = u16u8_pkg::KIND_CP;
    push_cmd.value = {5'd0, in_code_unit};
    push_cmd.last  = in_last_unit;
    pend_nxt       = pend_r;
    have_pend_nxt  = have_pend_r;
    if (have_pend_r) begin
      have_pend_nxt = 1'b0;
      if (is_lo) begin
        push_cmd.value = pair_val;
      end else begin
        push_cmd.kind = u16u8_pkg::KIND_BAD;
      end
    end else if (is_hi) begin
      if (in_last_unit) begin
        push_cmd.kind = u16u8_pkg::KIND_BAD;
      end else begin
        push_cmd.kind = u16u8_pkg::KIND_HOLD;
        pend_nxt      = in_code_unit[9:0];
        have_pend_nxt = 1'b1;
      end
    end else if (is_lo) begin
      push_cmd.kind = u16u8_pkg::KIND_BAD;
    end
    if (in_last_unit) begin
      have_pend_nxt = 1'b0;
    end
    if (push_cmd.value < u16u8_pkg::Lim1Byte) begin
      push_cmd.nb_m1 = 2'd0;
    end else if (push_cmd.value < u16u8_pkg::Lim2Byte) begin
      push_cmd.nb_m1 = 2'd1;
    end else if (push_cmd.value < u16u8_pkg::SuppBase) begin
      push_cmd.nb_m1 = 2'd2;
    end else begin
      push_cmd.nb_m1 = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_pend_r <= 1'b0;
      pend_r      <= '0;
    end else if (push) begin
      have_pend_r <= have_pend_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

// ----- hdl/u16u8_queue.sv -----
// ----------------------------------------------------------------------------
// u16u8_queue
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::cmd_t push_cmd,
  output logic            push_ready,
  output logic            head_valid,
  output u16u8_pkg::cmd_t head_cmd,
  input  logic            pop
);

  u16u8_pkg::cmd_t slot_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hdl/u16u8_back.sv -----
// ----------------------------------------------------------------------------
// u16u8_back
// emits utf-8 bytes and status beats for the command at the queue head
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [u16u8_pkg::CapW-1:0]    cap,
  input  logic                          head_valid,
  input  u16u8_pkg::cmd_t               head_cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u16u8_pkg::ByteW-1:0]   out_byte,
  output logic                          out_has_byte,
  output logic                          out_run_last,
  output logic [u16u8_pkg::StatW-1:0]   out_status
);

  logic [u16u8_pkg::CapW-1:0]  bw_r, bw_nxt;
  logic                        ab_r, ab_nxt;
  logic [2:0]                  idx_r, idx_nxt;
  logic                        ov_r;
  logic [u16u8_pkg::ByteW-1:0] ob_r;
  logic                        ohb_r, orl_r;
  logic [u16u8_pkg::StatW-1:0] ost_r;

  logic                        adv, full, emit;
  logic [2:0]                  nb;
  logic [u16u8_pkg::CapW:0]    bw_inc;
  logic [1:0]                  sh;
  logic [5:0]                  chunk;
  logic [u16u8_pkg::ByteW-1:0] lead, byte_val;
  logic [u16u8_pkg::ByteW-1:0] e_byte;
  logic                        e_hb, e_rl;
  logic [u16u8_pkg::StatW-1:0] e_st;

  assign adv    = !ov_r || out_ready;
  assign full   = (bw_r >= cap);
  assign nb     = {1'b0, head_cmd.nb_m1} + 3'd1;
  assign bw_inc = {1'b0, bw_r} + 14'd1;
  assign sh     = head_cmd.nb_m1 - idx_r[1:0];

  always_comb begin
    case (sh)
      2'd0:    chunk = head_cmd.value[5:0];
      2'd1:    chunk = head_cmd.value[11:6];
      2'd2:    chunk = head_cmd.value[17:12];
      default: chunk = {3'd0, head_cmd.value[20:18]};
    endcase
    case (head_cmd.nb_m1)
      2'd0:    lead = {1'b0, head_cmd.value[6:0]};
      2'd1:    lead = u16u8_pkg::Lead2 | {3'd0, head_cmd.value[10:6]};
      2'd2:    lead = u16u8_pkg::Lead3 | {4'd0, head_cmd.value[15:12]};
      default: lead = u16u8_pkg::Lead4 | {5'd0, head_cmd.value[20:18]};
    endcase
    byte_val = (idx_r == 3'd0) ? lead : (u16u8_pkg::ContMark | {2'd0, chunk});
  end

  always_comb begin
    pop     = 1'b0;
    emit    = 1'b0;
    e_byte  = '0;
    e_hb    = 1'b0;
    e_rl    = 1'b0;
    e_st    = u16u8_pkg::StatRun;
    bw_nxt  = bw_r;
    ab_nxt  = ab_r;
    idx_nxt = idx_r;
    if (head_valid && adv) begin
      if (ab_r) begin
        pop     = 1'b1;
        idx_nxt = 3'd0;
        if (head_cmd.last) begin
          ab_nxt = 1'b0;
          bw_nxt = '0;
        end
      end else if (full || (idx_r == 3'd0 && head_cmd.kind == u16u8_pkg::KIND_BAD)) begin
        // error beat ends the command
        emit    = 1'b1;
        e_rl    = 1'b1;
        e_st    = full ? u16u8_pkg::StatFull : u16u8_pkg::StatBadSur;
        pop     = 1'b1;
        idx_nxt = 3'd0;
        if (head_cmd.last) begin
          bw_nxt = '0;
        end else begin
          ab_nxt = 1'b1;
        end
      end else if (idx_r == 3'd0 && head_cmd.kind == u16u8_pkg::KIND_HOLD) begin
        pop = 1'b1;
      end else if (idx_r == nb) begin
        // string done beat
        emit    = 1'b1;
        e_rl    = 1'b1;
        e_st    = u16u8_pkg::StatOk;
        pop     = 1'b1;
        idx_nxt = 3'd0;
        bw_nxt  = '0;
      end else begin
        emit    = 1'b1;
        e_byte  = byte_val;
        e_hb    = 1'b1;
        bw_nxt  = bw_inc[u16u8_pkg::CapW-1:0];
        idx_nxt = idx_r + 3'd1;
        if (bw_inc < {1'b0, cap} && (idx_r + 3'd1) == nb && !head_cmd.last) begin
          e_rl    = 1'b1;
          pop     = 1'b1;
          idx_nxt = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r  <= '0;
      ab_r  <= 1'b0;
      idx_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      bw_r  <= bw_nxt;
      ab_r  <= ab_nxt;
      idx_r <= idx_nxt;
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r  <= e_byte;
      ohb_r <= e_hb;
      orl_r <= e_rl;
      ost_r <= e_st;
    end
  end

  assign out_valid    = ov_r;
  assign out_byte     = ob_r;
  assign out_has_byte = ohb_r;
  assign out_run_last = orl_r;
  assign out_status   = ost_r;

endmodule

// ----- hdl/utf16_to_utf8_transcoder_core.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// utf-16 code units in, utf-8 bytes and string status out
// ----------------------------------------------------------------------------
// in_*  : one utf-16 code unit per beat, in_last_unit flags the string end.
// out_* : one beat per result; a byte beat (out_has_byte) or a status beat
//         (out_status 1 ok, 2 bad surrogate, 3 output full) with run_last.
//         out_run_last marks the final beat caused by one input unit.
// cfg_* : writes the destination capacity in bytes, terminator included;
//         always ready, write only while the block is idle.
// timing: the front classifies a unit and writes it into the two-entry queue;
//         the back then puts its first beat in the output register. It emits
//         one beat per cycle while out_ready is high, at most 4 bytes plus
//         a status beat per unit; single-byte units stream at one per cycle.
//         A held high surrogate or a dropped unit is popped without a beat.
// reset : clears surrogate, byte count and abort state; capacity is 2048.
// stall : while out_ready is low the output register holds its beat, the
//         back stops and the queue fills; in_ready drops once it is full.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u16u8_pkg::CuW-1:0]     in_code_unit,
  input  logic                          in_last_unit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u16u8_pkg::ByteW-1:0]   out_byte,
  output logic                          out_has_byte,
  output logic                          out_run_last,
  output logic [u16u8_pkg::StatW-1:0]   out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [u16u8_pkg::CapW-1:0]    cfg_out_capacity
);

  logic [u16u8_pkg::CapW-1:0] cap_r;
  logic                       push, push_ready, head_valid, pop;
  u16u8_pkg::cmd_t            push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= u16u8_pkg::CapReset;
    end else if (cfg_valid) begin
      cap_r <= cfg_out_capacity;
    end
  end

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_ready   (push_ready)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  u16u8_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cap          (cap_r),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_run_last (out_run_last),
    .out_status   (out_status)
  );

endmodule

// ----- tb/utf16_to_utf8_transcoder_core_test.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core_test
// self-checking testbench for the utf-16 to utf-8 transcoder core
// ----------------------------------------------------------------------------
// Drives code units through the valid/ready input and computes the utf-8
// beats each accepted unit must produce. An independent encoder tracks the
// held surrogate, the byte count, the abort flag and the capacity setting.
// Every result beat is checked field by field against the oldest one due.
// Directed strings cover the encoding ranges, the surrogate faults and the
// capacity limit. Random strings follow, mostly well formed, under several
// capacity settings and idle patterns, plus a long receiver stall.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core_test;

  typedef struct packed {
    logic [u16u8_pkg::ByteW-1:0] data;
    logic                        has;
    logic                        rlast;
    logic [u16u8_pkg::StatW-1:0] stat;
  } utf8_beat_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [u16u8_pkg::CuW-1:0]    in_code_unit = '0;
  logic                         in_last_unit = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [u16u8_pkg::ByteW-1:0]  out_byte;
  logic                         out_has_byte;
  logic                         out_run_last;
  logic [u16u8_pkg::StatW-1:0]  out_status;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [u16u8_pkg::CapW-1:0]   cfg_out_capacity = '0;

  utf8_beat_t                   utf8_beats_due[$];
  int                           fail_count = 0;
  int                           send_idle_pct = 0;
  int                           recv_idle_pct = 0;
  int                           ready_hold = 0;

  int                           str_cap = u16u8_pkg::CapReset;
  int                           str_written = 0;
  logic [u16u8_pkg::PendW-1:0]  str_high = '0;
  logic                         str_have_high = 1'b0;
  logic                         str_aborted = 1'b0;

  utf16_to_utf8_transcoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_unit     (in_code_unit),
    .in_last_unit     (in_last_unit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_run_last     (out_run_last),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_out_capacity (cfg_out_capacity)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void push_beat(input logic [u16u8_pkg::ByteW-1:0] data,
                                    input logic has, input logic rlast,
                                    input logic [u16u8_pkg::StatW-1:0] stat);
    utf8_beat_t b;
    b.data  = data;
    b.has   = has;
    b.rlast = rlast;
    b.stat  = stat;
    utf8_beats_due.push_back(b);
  endfunction

  function automatic void clear_string_state();
    str_written   = 0;
    str_high      = '0;
    str_have_high = 1'b0;
    str_aborted   = 1'b0;
  endfunction

  function automatic void fail_string(input logic [u16u8_pkg::StatW-1:0] stat,
                                      input logic last);
    push_beat('0, 1'b0, 1'b1, stat);
    if (last) begin
      clear_string_state();
    end else begin
      str_aborted   = 1'b1;
      str_have_high = 1'b0;
      str_high      = '0;
    end
  endfunction

  function automatic void encode_unit(input logic [u16u8_pkg::CuW-1:0] cu,
                                      input logic last);
    int unsigned cp;
    int unsigned hi;
    int unsigned lo;
    int unsigned sh;
    int          adds;
    logic [u16u8_pkg::ByteW-1:0] lead;
    if (str_aborted) begin
      if (last) clear_string_state();
      return;
    end
    if (str_written >= str_cap) begin
      fail_string(u16u8_pkg::StatFull, last);
      return;
    end
    if (str_have_high) begin
      if (cu >= u16u8_pkg::LoSurBase && cu < u16u8_pkg::SurEnd) begin
        hi = {22'd0, str_high};
        lo = {22'd0, cu[9:0]};
        cp = ((hi << 10) | lo) + u16u8_pkg::SuppBase;
        str_have_high = 1'b0;
        str_high      = '0;
      end else begin
        fail_string(u16u8_pkg::StatBadSur, last);
        return;
      end
    end else if (cu >= u16u8_pkg::HiSurBase && cu < u16u8_pkg::LoSurBase) begin
      if (last) begin
        fail_string(u16u8_pkg::StatBadSur, last);
        return;
      end
      str_high      = cu[9:0];
      str_have_high = 1'b1;
      return;
    end else if (cu >= u16u8_pkg::LoSurBase && cu < u16u8_pkg::SurEnd) begin
      fail_string(u16u8_pkg::StatBadSur, last);
      return;
    end else begin
      cp = {16'd0, cu};
    end

    if (cp < u16u8_pkg::Lim1Byte) begin
      push_beat(cp[7:0], 1'b1, 1'b0, u16u8_pkg::StatRun);
      str_written++;
    end else begin
      if (cp < u16u8_pkg::Lim2Byte) begin
        adds = 1;
        lead = u16u8_pkg::Lead2;
      end else if (cp < u16u8_pkg::SuppBase) begin
        adds = 2;
        lead = u16u8_pkg::Lead3;
      end else begin
        adds = 3;
        lead = u16u8_pkg::Lead4;
      end
      sh = cp >> (6 * adds);
      push_beat(lead + sh[7:0], 1'b1, 1'b0, u16u8_pkg::StatRun);
      str_written++;
      while (adds > 0 && str_written < str_cap) begin
        adds--;
        sh = (cp >> (6 * adds)) & 32'h3F;
        push_beat(u16u8_pkg::ContMark + sh[7:0], 1'b1, 1'b0, u16u8_pkg::StatRun);
        str_written++;
      end
    end
    str_written = str_written & 32'h1FFF;

    if (str_written >= str_cap) begin
      fail_string(u16u8_pkg::StatFull, last);
      return;
    end
    if (last) begin
      push_beat('0, 1'b0, 1'b1, u16u8_pkg::StatOk);
      clear_string_state();
      return;
    end
    utf8_beats_due[utf8_beats_due.size()-1].rlast = 1'b1;
  endfunction

  // receiver: random idling, or a counted stall when ready_hold is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    utf8_beat_t b;
    if (rst_n && out_valid && out_ready) begin
      if (utf8_beats_due.size() == 0) begin
        $error("unexpected beat: byte %0h has %0b run_last %0b status %0d",
               out_byte, out_has_byte, out_run_last, out_status);
        fail_count++;
      end else begin
        b = utf8_beats_due.pop_front();
        if (out_byte !== b.data) begin
          $error("out_byte expected %0h actual %0h", b.data, out_byte);
          fail_count++;
        end
        if (out_has_byte !== b.has) begin
          $error("out_has_byte expected %0b actual %0b", b.has, out_has_byte);
          fail_count++;
        end
        if (out_run_last !== b.rlast) begin
          $error("out_run_last expected %0b actual %0b", b.rlast, out_run_last);
          fail_count++;
        end
        if (out_status !== b.stat) begin
          $error("out_status expected %0d actual %0d", b.stat, out_status);
          fail_count++;
        end
      end
    end
  end

  task automatic send_unit(input logic [u16u8_pkg::CuW-1:0] cu, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= cu;
    in_last_unit <= last;
    do @(posedge clk); while (!in_ready);
    encode_unit(cu, last);
  endtask

  // sender pauses until every due beat has come, then lets the back settle
  task automatic drain_beats();
    in_valid <= 1'b0;
    while (utf8_beats_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_capacity(input int cap);
    cfg_valid        <= 1'b1;
    cfg_out_capacity <= cap[u16u8_pkg::CapW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    str_cap = cap;
  endtask

  task automatic send_random_string(output int sent);
    int len;
    int r;
    logic [u16u8_pkg::CuW-1:0] v;
    sent = 0;
    len = $urandom_range(10, 1);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_unit(16'($urandom_range(16'h007F, 0)), i == len - 1);
        sent++;
      end else if (r < 48) begin
        send_unit(16'($urandom_range(16'h07FF, 16'h0080)), i == len - 1);
        sent++;
      end else if (r < 68) begin
        v = 16'($urandom_range(16'hF7FF, 16'h0800));
        if (v >= u16u8_pkg::HiSurBase) v = v + 16'h0800;
        send_unit(v, i == len - 1);
        sent++;
      end else if (r < 90) begin
        send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
        send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), i == len - 1);
        sent += 2;
      end else if (r < 94) begin
        send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), i == len - 1);
        sent++;
      end else if (r < 97) begin
        send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), i == len - 1);
        sent++;
      end else begin
        send_unit(16'($urandom_range(16'hFFFF, 0)), i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_directed_units();
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hE000, 1'b1);
    // high surrogate on the final unit
    send_unit(16'hD834, 1'b1);
    // low surrogate alone, then dropped units up to the end
    send_unit(16'hDC00, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b1);
    // held high followed by a plain unit
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b1);
    // held high followed by another high
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    drain_beats();
  endtask

  task automatic test_capacity_limit();
    write_capacity(1);
    send_unit(16'h20AC, 1'b1);
    drain_beats();
    write_capacity(3);
    send_unit(16'h20AC, 1'b1);
    send_unit(16'hD83D, 1'b0);
    send_unit(16'hDE00, 1'b0);
    send_unit(16'h0041, 1'b1);
    drain_beats();
    // capacity lowered in the middle of a string
    write_capacity(8);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b0);
    drain_beats();
    write_capacity(2);
    send_unit(16'h0044, 1'b0);
    send_unit(16'h0045, 1'b1);
    drain_beats();
  endtask

  task automatic test_random_strings();
    int caps[3];
    int sent;
    int count;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      caps[0] = $urandom_range(24, 2);
      caps[1] = 4096;
      caps[2] = (mode == 2) ? 1 : $urandom_range(60, 8);
      for (int c = 0; c < 3; c++) begin
        write_capacity(caps[c]);
        count = 0;
        while (count < 26) begin
          send_random_string(sent);
          count += sent;
        end
        drain_beats();
      end
    end
  endtask

  task automatic test_backpressure();
    int sent;
    int count;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(2048);
    ready_hold = 300;
    count = 0;
    while (count < 30) begin
      send_random_string(sent);
      count += sent;
    end
    drain_beats();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 80;
    test_directed_units();
    test_capacity_limit();
    test_random_strings();
    test_backpressure();
    drain_beats();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && utf8_beats_due.size() == 0) begin
      $display("utf16_to_utf8_transcoder_core_test passed");
    end else begin
      $display("utf16_to_utf8_transcoder_core_test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("utf16_to_utf8_transcoder_core_test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_transcoder_core.sv
tb/utf16_to_utf8_transcoder_core_test.sv
